>>> src/arp_request_responder_core_defines.svh
// assertion macros for the arp request responder
`ifndef ARP_REQUEST_RESPONDER_CORE_DEFINES_SVH
`define ARP_REQUEST_RESPONDER_CORE_DEFINES_SVH

`ifndef SYNTH
// assertion on an explicit clock and active-low reset
`define ARP_ASSERT_CLK(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("arp responder assertion failed");
// assertion on the module's clk and rst_n
`define ARP_ASSERT(lbl, prop) \
  `ARP_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define ARP_ASSERT_CLK(lbl, ck, rn, prop)
`define ARP_ASSERT(lbl, prop)
`endif

`endif

>>> src/arp_rr_pkg.sv
// shared types, constants and byte functions of the arp request responder
package arp_rr_pkg;

  localparam int REPLY_LENGTH_DEF = 60;
  localparam int ARP_END          = 42;
  localparam int POS_W            = 6;
  localparam int QUEUE_DEPTH      = 2;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 48;

  localparam logic [47:0] LOCAL_MAC_RST = 48'h5254_0012_3456;
  localparam logic [31:0] LOCAL_IP_RST  = 32'h0A00_020F;

  localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
  localparam logic [15:0] ARP_HTYPE    = 16'h0001;
  localparam logic [15:0] ARP_PTYPE    = 16'h0800;
  localparam logic [7:0]  ARP_HLEN     = 8'h06;
  localparam logic [7:0]  ARP_PLEN     = 8'h04;
  localparam logic [15:0] ARP_OP_REQ   = 16'h0001;
  localparam logic [15:0] ARP_OP_RESP  = 16'h0002;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_MAC = 1'b0,
    CFG_LOCAL_IP  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    TX_IDLE,
    TX_SEND
  } tx_state_t;

  // everything needed to build one reply
  typedef struct packed {
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] local_mac;
    logic [31:0] local_ip;
  } arp_job_t;

  // 1 when a checked header byte does not hold its expected value
  function automatic logic hdr_mismatch(logic [POS_W-1:0] pos, logic [7:0] b,
                                        logic [31:0] lip);
    logic [7:0] exp_b;
    logic       chk;
    exp_b = 8'h00;
    chk   = 1'b1;
    unique case (pos)
      6'd14:   exp_b = ARP_HTYPE[15:8];
      6'd15:   exp_b = ARP_HTYPE[7:0];
      6'd16:   exp_b = ARP_PTYPE[15:8];
      6'd17:   exp_b = ARP_PTYPE[7:0];
      6'd18:   exp_b = ARP_HLEN;
      6'd19:   exp_b = ARP_PLEN;
      6'd20:   exp_b = ARP_OP_REQ[15:8];
      6'd21:   exp_b = ARP_OP_REQ[7:0];
      6'd38:   exp_b = lip[31:24];
      6'd39:   exp_b = lip[23:16];
      6'd40:   exp_b = lip[15:8];
      6'd41:   exp_b = lip[7:0];
      default: chk   = 1'b0;
    endcase
    return chk && (exp_b != b);
  endfunction

  // byte i of the reply frame
  function automatic logic [7:0] reply_byte(logic [POS_W-1:0] i, arp_job_t j);
    logic [7:0] r;
    r = 8'h00;
    if (i < 6'd6) begin
      r = j.sender_mac[8*(5-int'(i)) +: 8];
    end else if (i < 6'd12) begin
      r = j.local_mac[8*(11-int'(i)) +: 8];
    end else if (i < 6'd22) begin
      unique case (i)
        6'd12:   r = ETH_TYPE_ARP[15:8];
        6'd13:   r = ETH_TYPE_ARP[7:0];
        6'd14:   r = ARP_HTYPE[15:8];
        6'd15:   r = ARP_HTYPE[7:0];
        6'd16:   r = ARP_PTYPE[15:8];
        6'd17:   r = ARP_PTYPE[7:0];
        6'd18:   r = ARP_HLEN;
        6'd19:   r = ARP_PLEN;
        6'd20:   r = ARP_OP_RESP[15:8];
        6'd21:   r = ARP_OP_RESP[7:0];
        default: r = 8'h00;
      endcase
    end else if (i < 6'd28) begin
      r = j.local_mac[8*(27-int'(i)) +: 8];
    end else if (i < 6'd32) begin
      r = j.local_ip[8*(31-int'(i)) +: 8];
    end else if (i < 6'd38) begin
      r = j.sender_mac[8*(37-int'(i)) +: 8];
    end else if (i < 6'd42) begin
      r = j.sender_ip[8*(41-int'(i)) +: 8];
    end
    return r;
  endfunction

endpackage

>>> src/arp_request_responder_core.sv
// top level of the arp request responder: config registers, rx, job queue, tx
// Answers ARP requests for the local IPv4 address. Received Ethernet frames
// stream in one byte per item on in_*, with in_tlast on the final byte, and
// are taken at one byte per cycle. The ARP header at byte offsets 14..41 is
// checked on the fly (hardware type 1, protocol 0x0800, lengths 6 and 4,
// opcode request, target IP equal to local_ip); the ethertype is not checked
// and bytes past offset 41 are ignored. When a frame of at least 42 bytes
// passes, its final byte queues a reply job holding the sender addresses and
// the local_mac/local_ip values at that byte. The transmit side plays each
// job out as a REPLY_LENGTH-byte ARP reply (opcode 2, zero padded past offset
// 41) on out_*, one byte per cycle while out_tready is high, with out_tlast
// on the last byte; consecutive replies follow with no gap. A two-entry job
// queue lets the receive side keep taking bytes while replies are sent; it
// stalls in_tready only when the queue is full. Registers are written through
// cfg_* (index 0 local_mac, index 1 local_ip), always ready; write them while
// idle.
module arp_request_responder_core #(
  parameter int REPLY_LENGTH = arp_rr_pkg::REPLY_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // received frame bytes
  input  logic [7:0]                       in_tdata,   // rx_byte
  input  logic                             in_tlast,   // rx_last
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // reply frame bytes
  output logic [7:0]                       out_tdata,  // tx_byte
  output logic                             out_tlast,  // tx_last
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [arp_rr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arp_rr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import arp_rr_pkg::*;

  logic [47:0] local_mac_r;
  logic [31:0] local_ip_r;

  // job handoff between the receive side and the queue
  logic     push_valid, push_ready;
  arp_job_t push_job;
  // job handoff between the queue and the transmit side
  logic     pop_valid, pop_ready;
  arp_job_t pop_job;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_mac_r <= LOCAL_MAC_RST;
      local_ip_r  <= LOCAL_IP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LOCAL_MAC: local_mac_r <= cfg_data[47:0];
        CFG_LOCAL_IP:  local_ip_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // front: parse and check, one byte per cycle while the job queue has room
  arp_rr_rx u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .local_mac  (local_mac_r),
    .local_ip   (local_ip_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // pending replies
  arp_rr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // back: reply generator with an output register
  arp_rr_tx #(
    .REPLY_LENGTH (REPLY_LENGTH)
  ) u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

endmodule

>>> src/arp_rr_rx.sv
// receive side: counts frame bytes, checks the arp header, queues reply jobs
`include "arp_request_responder_core_defines.svh"
module arp_rr_rx (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_tdata,    // rx_byte
  input  logic                 in_tlast,    // rx_last
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [47:0]          local_mac,
  input  logic [31:0]          local_ip,
  output logic                 push_valid,
  input  logic                 push_ready,
  output arp_rr_pkg::arp_job_t push_job
);
  import arp_rr_pkg::*;

  logic [POS_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic             ok_r, ok_nxt, ok_upd;
  logic [47:0]      smac_r, smac_nxt;
  logic [31:0]      sip_r, sip_nxt;
  logic             acc;
  logic             in_hdr;

  assign in_tready = push_ready;
  assign acc       = in_tvalid && in_tready;
  assign in_hdr    = cnt_r < POS_W'(ARP_END);

  always_comb begin
    cnt_upd  = in_hdr ? cnt_r + 1'b1 : cnt_r;
    ok_upd   = in_hdr ? ok_r && !hdr_mismatch(cnt_r, in_tdata, local_ip) : ok_r;
    smac_nxt = smac_r;
    sip_nxt  = sip_r;
    if (acc) begin
      case (cnt_r) inside
        [6'd22:6'd27]: smac_nxt = {smac_r[39:0], in_tdata};
        [6'd28:6'd31]: sip_nxt  = {sip_r[23:0], in_tdata};
        default: ;
      endcase
    end
    cnt_nxt = cnt_r;
    ok_nxt  = ok_r;
    if (acc) begin
      // end of frame restarts the parser whether or not a reply goes out
      cnt_nxt = in_tlast ? '0 : cnt_upd;
      ok_nxt  = in_tlast ? 1'b1 : ok_upd;
    end
  end

  assign push_valid = acc && in_tlast && (cnt_upd == POS_W'(ARP_END)) && ok_upd;
  assign push_job   = '{sender_mac: smac_nxt, sender_ip: sip_nxt,
                        local_mac: local_mac, local_ip: local_ip};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ok_r   <= 1'b1;
      smac_r <= '0;
      sip_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      ok_r   <= ok_nxt;
      smac_r <= smac_nxt;
      sip_r  <= sip_nxt;
    end
  end

  `ARP_ASSERT(a_rx_restart, acc && in_tlast |=> cnt_r == '0 && ok_r)
  `ARP_ASSERT(a_rx_cnt_sat, cnt_r <= POS_W'(ARP_END))

endmodule

>>> src/arp_rr_queue.sv
// short job queue between the receive and transmit sides
`include "arp_request_responder_core_defines.svh"
module arp_rr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  arp_rr_pkg::arp_job_t push_job,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output arp_rr_pkg::arp_job_t pop_job
);
  import arp_rr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  arp_job_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

  `ARP_ASSERT(a_q_bound, count_r <= CNT_W'(QUEUE_DEPTH))

endmodule

>>> src/arp_rr_tx.sv
// transmit side: plays one queued job out as a reply frame, byte by byte
`include "arp_request_responder_core_defines.svh"
module arp_rr_tx #(
  parameter int REPLY_LENGTH = arp_rr_pkg::REPLY_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  arp_rr_pkg::arp_job_t pop_job,
  output logic [7:0]           out_tdata,   // tx_byte
  output logic                 out_tlast,   // tx_last
  output logic                 out_tvalid,
  input  logic                 out_tready
);
  import arp_rr_pkg::*;

  localparam int CNT_W = $clog2(REPLY_LENGTH);

  tx_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  arp_job_t         job_r;
  logic             adv, last_idx, do_pop;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      TX_IDLE: if (pop_valid) state_nxt = TX_SEND;
      TX_SEND: if (adv && last_idx && !pop_valid) state_nxt = TX_IDLE;
      default: state_nxt = TX_IDLE;
    endcase
  end

  // outputs and counter
  always_comb begin
    adv       = (state_r == TX_SEND) && (!out_valid_r || out_tready);
    last_idx  = cnt_r == CNT_W'(REPLY_LENGTH - 1);
    pop_ready = (state_r == TX_IDLE) || (adv && last_idx);
    do_pop    = pop_valid && pop_ready;
    cnt_nxt   = cnt_r;
    if (do_pop || (adv && last_idx)) begin
      cnt_nxt = '0;
    end else if (adv) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TX_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (do_pop) job_r <= pop_job;
    if (adv) begin
      out_byte_r <= reply_byte(POS_W'(cnt_r), job_r);
      out_last_r <= last_idx;
    end
  end

  `ARP_ASSERT(a_tx_start, do_pop |=> state_r == TX_SEND && cnt_r == '0)
  `ARP_ASSERT(a_tx_idle_cnt, state_r == TX_IDLE |-> cnt_r == '0)

endmodule

>>> sim/tb.sv
// self-checking testbench for the arp request responder core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arp_rr_pkg::*;

  localparam int REPLY_BYTES    = REPLY_LENGTH_DEF;
  localparam int HOLD_CYCLES    = 500;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;

  // checked request header bytes at offsets 14..21
  localparam logic [63:0] REQ_HEADER = {ARP_HTYPE, ARP_PTYPE, ARP_HLEN, ARP_PLEN, ARP_OP_REQ};
  // fixed reply bytes at offsets 12..21
  localparam logic [79:0] REPLY_HEADER = {ETH_TYPE_ARP, ARP_HTYPE, ARP_PTYPE, ARP_HLEN,
                                          ARP_PLEN, ARP_OP_RESP};

  typedef enum {
    FR_REQUEST,
    FR_SHORT,
    FR_BAD_FIELD,
    FR_NOISE
  } frame_kind_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } reply_byte_t;

  logic                  clk;
  logic                  rst_n;
  logic [7:0]            in_tdata;   // rx_byte
  logic                  in_tlast;   // rx_last
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            out_tdata;  // tx_byte
  logic                  out_tlast;  // tx_last
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  arp_request_responder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // responder state as the predictor sees it
  logic [47:0] exp_local_mac = LOCAL_MAC_RST;
  logic [31:0] exp_local_ip  = LOCAL_IP_RST;
  int          rx_count      = 0;
  bit          hdr_ok        = 1'b1;
  logic [47:0] sender_mac    = '0;
  logic [31:0] sender_ip     = '0;

  reply_byte_t reply_bytes_q[$];
  logic [7:0]  frame_q[$];

  int mismatches   = 0;
  int stall_cycles = 0;
  bit idle_en      = 1'b1;
  bit hold_req     = 1'b0;
  int hold_left    = 0;
  int sink_wait    = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // track one accepted rx byte and queue the reply bytes it causes
  function automatic void arp_predict(input logic [7:0] b, input logic last);
    logic [335:0] reply;
    reply_byte_t  rb;
    if (rx_count < ARP_END) begin
      if (rx_count >= 14 && rx_count <= 21 && b != REQ_HEADER[8*(21-rx_count) +: 8]) begin
        hdr_ok = 1'b0;
      end
      // target ip is compared against the register as each byte arrives
      if (rx_count >= 38 && b != exp_local_ip[8*(41-rx_count) +: 8]) begin
        hdr_ok = 1'b0;
      end
      if (rx_count >= 22 && rx_count <= 27) begin
        sender_mac = {sender_mac[39:0], b};
      end
      if (rx_count >= 28 && rx_count <= 31) begin
        sender_ip = {sender_ip[23:0], b};
      end
      rx_count++;
    end
    if (last) begin
      if (rx_count >= ARP_END && hdr_ok) begin
        reply = {sender_mac, exp_local_mac, REPLY_HEADER, exp_local_mac, exp_local_ip,
                 sender_mac, sender_ip};
        for (int i = 0; i < REPLY_BYTES; i++) begin
          rb.data = (i < ARP_END) ? reply[8*(ARP_END-1-i) +: 8] : 8'h00;
          rb.last = (i == REPLY_BYTES - 1);
          reply_bytes_q.push_back(rb);
        end
      end
      rx_count = 0;
      hdr_ok   = 1'b1;
    end
  endfunction

  // offer one rx byte, with an optional idle burst first; valid stays up afterwards
  task automatic push_rx_byte(input logic [7:0] b, input logic last);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    arp_predict(b, last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      push_rx_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // well-formed request for the current local ip, random everywhere else
  task automatic build_request(input int len);
    frame_q.delete();
    for (int i = 0; i < len; i++) begin
      if (i >= 14 && i <= 21) begin
        frame_q.push_back(REQ_HEADER[8*(21-i) +: 8]);
      end else if (i >= 38 && i < ARP_END) begin
        frame_q.push_back(exp_local_ip[8*(41-i) +: 8]);
      end else begin
        frame_q.push_back(8'($urandom));
      end
    end
  endtask

  task automatic build_frame(input frame_kind_t kind);
    int pos;
    int len;
    case (kind)
      FR_REQUEST: begin
        // mostly minimal frames, some long enough to pass the 6-bit count range
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(43, 70) : ARP_END;
        build_request(len);
      end
      FR_SHORT: begin
        len = ($urandom_range(0, 1) == 0) ? ARP_END - 1 : $urandom_range(1, ARP_END - 1);
        build_request(len);
      end
      FR_BAD_FIELD: begin
        build_request(ARP_END + $urandom_range(0, 3));
        pos = $urandom_range(0, 11);
        pos = (pos < 8) ? 14 + pos : 30 + pos;
        frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
      end
      default: begin
        len = $urandom_range(1, 70);
        frame_q.delete();
        repeat (len) frame_q.push_back(8'($urandom));
      end
    endcase
  endtask

  // drop valid, wait for every queued reply byte, then let the pipeline settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (reply_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_local_regs(input logic [47:0] mac, input logic [31:0] ip);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LOCAL_MAC;
    cfg_data  <= mac;
    do @(posedge clk); while (!cfg_ready);
    exp_local_mac = mac;
    // upper data bits are don't-care for the ip register
    cfg_index <= CFG_LOCAL_IP;
    cfg_data  <= {16'($urandom), ip};
    do @(posedge clk); while (!cfg_ready);
    exp_local_ip = ip;
    cfg_valid <= 1'b0;
  endtask

  // frames that end before the arp header is complete never answer
  task automatic test_short_frames();
    push_rx_byte(8'h00, 1'b1);
    push_rx_byte(8'hff, 1'b1);
    push_rx_byte(8'ha5, 1'b0);
    push_rx_byte(8'h5a, 1'b1);
    build_request(20);
    send_frame();
    wait_drained();
  endtask

  // sink holds off long enough for the job queue to fill and stall rx;
  // runs on the reset register values
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (3) begin
      build_request(ARP_END);
      send_frame();
    end
    frame_q.delete();
    repeat (4) frame_q.push_back(8'($urandom));
    send_frame();
    wait_drained();
  endtask

  task automatic test_reg_extremes();
    write_local_regs('0, '0);
    build_frame(FR_REQUEST);
    send_frame();
    wait_drained();
  endtask

  // closing phase runs at full rate on both sides
  task automatic test_no_idle();
    idle_en = 1'b0;
    write_local_regs('1, '1);
    build_frame(FR_BAD_FIELD);
    send_frame();
    wait_drained();
  endtask

  // reply sink: random stall bursts plus the requested long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait  <= 0;
      hold_left  <= 0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left  <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait  <= sink_wait - 1;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      sink_wait  <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each accepted reply byte with the oldest expected one
  always @(posedge clk) begin
    reply_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_bytes_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected reply byte: data %02h last %0b", out_tdata, out_tlast);
        end
      end else begin
        want = reply_bytes_q.pop_front();
        if (out_tdata !== want.data || out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("reply byte mismatch: expected data %02h last %0b, got data %02h last %0b",
                     want.data, want.last, out_tdata, out_tlast);
          end
        end
      end
    end
  end

  // ends the run when no channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_LOCAL_MAC;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_frames();
    test_backpressure();
    test_reg_extremes();
    test_no_idle();

    if (mismatches == 0 && reply_bytes_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
